@@ src/swag_pkg.sv @@
// shared types and constants of the strided window address generator
`timescale 1ns / 1ps

package swag_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAX_AXES   = 7;

    // field positions inside one axis register
    localparam int EXT_LSB   = 0;
    localparam int FIRST_LSB = 16;
    localparam int JUMP_LSB  = 32;
    localparam int COUNT_LSB = 48;

    // width of the index ports
    localparam int OUT_W = 32;

    // odometer signals that ripple from cell to cell
    typedef struct packed {
        logic carry;
        logic fin;
    } chain_t;

    // setup sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic shift;
        logic done;
        logic err;
        logic all_one;
    } setup_stat_t;

endpackage

@@ src/swag_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module swag_div #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(WIDTH);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (!diff[WIDTH]) begin
                rem_reg <= diff[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/swag_cell.sv @@
// one odometer cell: position, count and index step of one axis
`timescale 1ns / 1ps

module swag_cell import swag_pkg::*; #(
    parameter int EXTENT_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   load_en,
    input  logic [EXTENT_BITS-1:0] load_cnt_m1,
    input  logic [INDEX_BITS-1:0]  load_delta,
    input  chain_t                 chain_in,
    input  logic [INDEX_BITS-1:0]  acc_in,
    output logic [EXTENT_BITS-1:0] cnt_m1_out,
    output logic [INDEX_BITS-1:0]  delta_out,
    output chain_t                 chain_out,
    output logic [INDEX_BITS-1:0]  acc_out
);

    logic [EXTENT_BITS-1:0] pos_reg;
    logic [EXTENT_BITS-1:0] pos_next;
    logic [EXTENT_BITS-1:0] pos_step;
    logic [EXTENT_BITS-1:0] cnt_m1_reg;
    logic [INDEX_BITS-1:0]  delta_reg;
    logic                   at_end;
    logic                   inc;
    logic                   wrap;

    assign at_end = (pos_reg == cnt_m1_reg);
    assign inc    = chain_in.carry && !at_end;
    assign wrap   = chain_in.carry && at_end;

    always_comb begin
        if (inc) begin
            pos_step = pos_reg + EXTENT_BITS'(1);
        end else if (wrap) begin
            pos_step = '0;
        end else begin
            pos_step = pos_reg;
        end
        if (load_en) begin
            pos_next = '0;
        end else if (step_en) begin
            pos_next = pos_step;
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            cnt_m1_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            if (load_en) begin
                cnt_m1_reg <= load_cnt_m1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            delta_reg <= load_delta;
        end
    end

    assign chain_out.carry = wrap;
    assign chain_out.fin   = chain_in.fin && (pos_step == cnt_m1_reg);
    assign acc_out         = acc_in | (inc ? delta_reg : '0);
    assign cnt_m1_out      = cnt_m1_reg;
    assign delta_out       = delta_reg;

endmodule

@@ src/swag_setup.sv @@
// restart sequencer: resolves each axis and works out strides and steps
`timescale 1ns / 1ps

module swag_setup import swag_pkg::*; #(
    parameter int NUM_AXES    = 7,
    parameter int EXTENT_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [NUM_AXES-1:0][4*EXTENT_BITS-1:0]   cfg_window,
    output setup_stat_t                              stat,
    output logic [EXTENT_BITS-1:0]                   cnt_m1,
    output logic [INDEX_BITS-1:0]                    delta,
    output logic [INDEX_BITS-1:0]                    src_start
);

    localparam int EB    = EXTENT_BITS;
    localparam int AX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int MA_W  = (INDEX_BITS > EXTENT_BITS) ? INDEX_BITS : EXTENT_BITS;
    localparam int P_W   = MA_W + EXTENT_BITS;
    localparam int CHK_W = 2 * EXTENT_BITS + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_ERR   = 9'b000001000,
        S_BASE  = 9'b000010000,
        S_SSTR  = 9'b000100000,
        S_SPAN  = 9'b001000000,
        S_STR   = 9'b010000000,
        S_SHIFT = 9'b100000000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [AX_W-1:0]        ax_reg;
    logic [EB-1:0]          ext_reg;
    logic [EB-1:0]          first_reg;
    logic [EB-1:0]          jump_reg;
    logic [EB-1:0]          cnt_m1_reg;
    logic [INDEX_BITS-1:0]  stride_reg;
    logic [INDEX_BITS-1:0]  cumspan_reg;
    logic [INDEX_BITS-1:0]  delta_reg;
    logic [INDEX_BITS-1:0]  src_start_reg;
    logic [P_W-1:0]         mul_reg;
    logic                   err_reg;
    logic                   all_one_reg;

    logic [4*EB-1:0]        win;
    logic [EB-1:0]          f_ext;
    logic [EB-1:0]          f_first;
    logic [EB-1:0]          f_jump;
    logic [EB-1:0]          f_count;
    logic                   div_start;
    logic                   div_done;
    logic [EB-1:0]          div_q;
    logic [MA_W-1:0]        mul_a;
    logic [EB-1:0]          mul_b;
    logic [CHK_W-1:0]       reach;
    logic                   last_axis;

    assign win     = cfg_window[ax_reg];
    assign f_ext   = win[EB-1:0];
    assign f_first = win[EB +: EB];
    assign f_jump  = (win[2*EB +: EB] == '0) ? EB'(1) : win[2*EB +: EB];
    assign f_count = win[3*EB +: EB];

    assign last_axis = (ax_reg == AX_W'(NUM_AXES - 1));
    assign div_start = (state_reg == S_FETCH) && (f_count == '0) && (f_first < f_ext);

    // furthest position the window touches, plus one
    assign reach = CHK_W'(first_reg) + CHK_W'(1) + CHK_W'(mul_reg[2*EB-1:0]);

    swag_div #(
        .WIDTH(EB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (f_ext - f_first - EB'(1)),
        .divisor  (f_jump),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = MA_W'(stride_reg);
        mul_b = first_reg;
        case (state_reg)
            S_ERR: begin
                mul_a = MA_W'(jump_reg);
                mul_b = cnt_m1_reg;
            end
            S_SSTR: mul_b = jump_reg;
            S_SPAN: begin
                mul_a = MA_W'(mul_reg[INDEX_BITS-1:0]);
                mul_b = cnt_m1_reg;
            end
            S_STR: mul_b = ext_reg;
            default: mul_b = first_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_FETCH;
            S_FETCH: state_next = div_start ? S_DIV : S_ERR;
            S_DIV:   if (div_done) state_next = S_ERR;
            S_ERR:   state_next = S_BASE;
            S_BASE:  state_next = S_SSTR;
            S_SSTR:  state_next = S_SPAN;
            S_SPAN:  state_next = S_STR;
            S_STR:   state_next = S_SHIFT;
            S_SHIFT: state_next = last_axis ? S_IDLE : S_FETCH;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ax_reg        <= '0;
            src_start_reg <= '0;
            err_reg       <= 1'b0;
            all_one_reg   <= 1'b1;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        ax_reg        <= '0;
                        src_start_reg <= '0;
                        err_reg       <= 1'b0;
                        all_one_reg   <= 1'b1;
                    end
                end
                S_ERR:   all_one_reg   <= all_one_reg && (cnt_m1_reg == '0);
                S_BASE:  err_reg       <= err_reg || (CHK_W'(ext_reg) < reach);
                S_SSTR:  src_start_reg <= src_start_reg + mul_reg[INDEX_BITS-1:0];
                S_SHIFT: if (!last_axis) ax_reg <= ax_reg + AX_W'(1);
                default: ax_reg        <= ax_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= P_W'(mul_a) * P_W'(mul_b);
        case (state_reg)
            S_IDLE: begin
                stride_reg  <= INDEX_BITS'(1);
                cumspan_reg <= '0;
            end
            S_FETCH: begin
                ext_reg    <= f_ext;
                first_reg  <= f_first;
                jump_reg   <= f_jump;
                cnt_m1_reg <= (f_count == '0) ? '0 : f_count - EB'(1);
            end
            S_DIV:   if (div_done) cnt_m1_reg <= div_q;
            S_SPAN:  delta_reg   <= mul_reg[INDEX_BITS-1:0] - cumspan_reg;
            S_STR:   cumspan_reg <= cumspan_reg + mul_reg[INDEX_BITS-1:0];
            S_SHIFT: stride_reg  <= mul_reg[INDEX_BITS-1:0];
            default: cumspan_reg <= cumspan_reg;
        endcase
    end

    assign stat.busy    = (state_reg != S_IDLE);
    assign stat.shift   = (state_reg == S_SHIFT);
    assign stat.done    = (state_reg == S_SHIFT) && last_axis;
    assign stat.err     = err_reg;
    assign stat.all_one = all_one_reg;
    assign cnt_m1       = cnt_m1_reg;
    assign delta        = delta_reg;
    assign src_start    = src_start_reg;

endmodule

@@ src/strided_window_address_generator_core.sv @@
// top level of the strided window address generator
`timescale 1ns / 1ps

// Walks a strided window of a row-major array of up to seven axes and emits,
// per beat, the source index in the full array and the destination index in
// the window, plus last and bad_window flags.
// - config: write cfg_wdata to axis register cfg_addr while the block is idle;
//   registers are sampled only by a restart beat
// - input beat with s_restart high: the setup sequencer resolves every axis
//   (one shared multiplier, one bit-serial divider) and shifts its count and
//   index step into the chain of odometer cells, axis 0 ending in cell 0;
//   per axis it fetches, divides only for an axis whose count field is zero
//   and whose first position lies inside the extent, then checks, multiplies
//   and shifts, and s_ready stays low meanwhile
// - input beat with s_restart low: the cells ripple the carry combinationally,
//   one add updates the source index; the result is ready the next cycle and
//   one beat per cycle is sustained while m_ready stays high
// - the result sits in an output register; a new advance beat is taken in
//   the same cycle the waiting result is taken, and s_ready drops while the
//   receiver stalls
// - reset: all axes extent 1, count 1; advances before any restart return
//   index 0, last set, bad_window clear

module strided_window_address_generator_core import swag_pkg::*; #(
    parameter int NUM_AXES    = 7,
    parameter int EXTENT_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_src_index,
    output logic [OUT_W-1:0]      m_dst_index,
    output logic                  m_last,
    output logic                  m_bad_window
);

    localparam int EB    = EXTENT_BITS;
    localparam int DST_W = (INDEX_BITS < OUT_W) ? INDEX_BITS : OUT_W;

    // axis registers, packed {count, jump, first, extent}
    logic [NUM_AXES-1:0][4*EB-1:0] cfg_reg;

    setup_stat_t            stat;
    logic [EB-1:0]          setup_cnt_m1;
    logic [INDEX_BITS-1:0]  setup_delta;
    logic [INDEX_BITS-1:0]  src_start;

    // chain wiring, index i feeds cell i
    chain_t                 chain [0:NUM_AXES];
    logic [INDEX_BITS-1:0]  acc   [0:NUM_AXES];
    logic [EB-1:0]          cell_cnt   [0:NUM_AXES-1];
    logic [INDEX_BITS-1:0]  cell_delta [0:NUM_AXES-1];

    logic [INDEX_BITS-1:0]  src_reg;
    logic [DST_W-1:0]       dst_reg;
    logic                   last_reg;
    logic                   bad_reg;
    logic                   m_valid_reg;

    logic                   in_beat;
    logic                   adv;
    logic                   restart_beat;

    // input opens when setup is idle and the output register is empty or being taken
    assign s_ready      = !stat.busy && (!m_valid_reg || m_ready);
    assign in_beat      = s_valid && s_ready;
    assign adv          = in_beat && !s_restart;
    assign restart_beat = in_beat && s_restart;

    // config register file
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_cfg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cfg_reg[i] <= {EB'(1), EB'(1), EB'(0), EB'(1)};
            end else if (cfg_wr_en && (cfg_addr == CFG_IDX_W'(i))) begin
                cfg_reg[i] <= {cfg_wdata[COUNT_LSB +: EB], cfg_wdata[JUMP_LSB +: EB],
                               cfg_wdata[FIRST_LSB +: EB], cfg_wdata[EXT_LSB +: EB]};
            end
        end
    end

    swag_setup #(
        .NUM_AXES    (NUM_AXES),
        .EXTENT_BITS (EXTENT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_setup (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (restart_beat),
        .cfg_window (cfg_reg),
        .stat       (stat),
        .cnt_m1     (setup_cnt_m1),
        .delta      (setup_delta),
        .src_start  (src_start)
    );

    // odometer: carry enters at axis 0, fastest axis
    assign chain[0].carry = 1'b1;
    assign chain[0].fin   = 1'b1;
    assign acc[0]         = '0;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_cell
        logic [EB-1:0]         ld_cnt;
        logic [INDEX_BITS-1:0] ld_delta;

        // setup results shift in at the top cell and move down one per axis
        if (i == NUM_AXES - 1) begin : g_top
            assign ld_cnt   = setup_cnt_m1;
            assign ld_delta = setup_delta;
        end else begin : g_mid
            assign ld_cnt   = cell_cnt[i+1];
            assign ld_delta = cell_delta[i+1];
        end

        swag_cell #(
            .EXTENT_BITS (EXTENT_BITS),
            .INDEX_BITS  (INDEX_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step_en     (adv),
            .load_en     (stat.shift),
            .load_cnt_m1 (ld_cnt),
            .load_delta  (ld_delta),
            .chain_in    (chain[i]),
            .acc_in      (acc[i]),
            .cnt_m1_out  (cell_cnt[i]),
            .delta_out   (cell_delta[i]),
            .chain_out   (chain[i+1]),
            .acc_out     (acc[i+1])
        );
    end

    // running indices and flags, which are also the output register
    always_ff @(posedge aclk) begin
        if (stat.done) begin
            src_reg  <= src_start;
            dst_reg  <= '0;
            last_reg <= stat.all_one;
        end else if (adv) begin
            // carry out of the last cell: window finished, wrap to first element
            if (chain[NUM_AXES].carry) begin
                src_reg <= src_start;
                dst_reg <= '0;
            end else begin
                src_reg <= src_reg + acc[NUM_AXES];
                dst_reg <= dst_reg + DST_W'(1);
            end
            last_reg <= chain[NUM_AXES].fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            bad_reg     <= 1'b0;
        end else begin
            if (stat.done || adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (stat.done) begin
                bad_reg <= stat.err;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_src_index  = OUT_W'(src_reg);
    assign m_dst_index  = OUT_W'(dst_reg);
    assign m_last       = last_reg;
    assign m_bad_window = bad_reg;

`ifndef SYNTHESIS
    // no beat slips in while the sequencer rebuilds the chain
    a_no_beat_in_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_ready)
        else $error("input beat possible during setup");

    // a restart beat always starts the sequencer
    a_restart_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        restart_beat |=> stat.busy)
        else $error("restart did not start setup");

    // end of setup presents the first pair
    a_done_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> (m_valid && (m_dst_index == '0)))
        else $error("first pair missing after setup");

    // wrapping the whole window returns the destination index to zero
    a_wrap_dst: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && chain[NUM_AXES].carry) |=> (dst_reg == '0))
        else $error("destination index not cleared on wrap");

    // a waiting result that is not taken keeps the input closed
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input beat possible while result stalled");
`endif

endmodule

@@ tb/window_index_checker.sv @@
// checker that predicts and compares the index pairs of the window address generator
`timescale 1ns / 1ps

module window_index_checker import swag_pkg::*; #(
    parameter int NUM_AXES    = 7,
    parameter int EXTENT_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_restart,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [OUT_W-1:0]      m_src_index,
    input  logic [OUT_W-1:0]      m_dst_index,
    input  logic                  m_last,
    input  logic                  m_bad_window,
    output int                    errors,
    output int                    pending
);

    localparam logic [63:0] EXT_MASK     = (64'd1 << EXTENT_BITS) - 64'd1;
    localparam logic [63:0] IDX_MASK     = (64'd1 << INDEX_BITS) - 64'd1;
    localparam logic [63:0] WINDOW_RESET = 64'h0001_0001_0000_0001;

    typedef struct packed {
        logic [OUT_W-1:0] src;
        logic [OUT_W-1:0] dst;
        logic             last;
        logic             bad;
    } index_pair_t;

    // shadow of the axis registers and of the walk state
    logic [CFG_DATA_W-1:0] window_reg [MAX_AXES];
    logic [31:0]           axis_pos   [MAX_AXES];
    logic [31:0]           axis_count [MAX_AXES];
    logic [63:0]           axis_base  [MAX_AXES];
    logic [63:0]           axis_step  [MAX_AXES];
    logic [31:0]           dest_count;
    logic                  window_bad;

    index_pair_t expected_pairs [$];
    index_pair_t got, want, queued;
    int          mismatch_total = 0;

    assign errors = mismatch_total;

    function automatic logic [63:0] field_of(input logic [63:0] r, input int lsb);
        return (r >> lsb) & EXT_MASK;
    endfunction

    // restart: resolve jumps and counts, build strides, check each window
    function automatic void latch_window();
        logic [63:0] span, ext, first, jump, cnt;
        logic        err;
        span = 64'd1;
        err  = 1'b0;
        for (int i = 0; i < MAX_AXES; i++) begin
            ext   = 64'd1;
            first = 64'd0;
            jump  = 64'd1;
            cnt   = 64'd1;
            if (i < NUM_AXES) begin
                ext   = field_of(window_reg[i], EXT_LSB);
                first = field_of(window_reg[i], FIRST_LSB);
                jump  = field_of(window_reg[i], JUMP_LSB);
                cnt   = field_of(window_reg[i], COUNT_LSB);
            end
            if (jump == 64'd0)
                jump = 64'd1;
            if (cnt == 64'd0)
                cnt = (first < ext) ? (ext - 64'd1 - first) / jump + 64'd1 : 64'd1;
            if (ext < 64'd1 + first + jump * (cnt - 64'd1))
                err = 1'b1;
            axis_count[i] = cnt[31:0];
            axis_pos[i]   = '0;
            axis_base[i]  = (span * first) & IDX_MASK;
            axis_step[i]  = (span * jump) & IDX_MASK;
            span          = (span * ext) & IDX_MASK;
        end
        dest_count = '0;
        window_bad = err;
    endfunction

    // odometer step, axis 0 fastest, wraps to the first element
    function automatic void step_odometer();
        logic carry;
        carry = 1'b1;
        for (int i = 0; i < MAX_AXES; i++) begin
            if (carry) begin
                if (axis_pos[i] + 32'd1 < axis_count[i]) begin
                    axis_pos[i] = axis_pos[i] + 32'd1;
                    carry       = 1'b0;
                end else begin
                    axis_pos[i] = '0;
                end
            end
        end
        dest_count = carry ? 32'd0 : dest_count + 32'd1;
    endfunction

    function automatic index_pair_t next_index_pair(input logic restart_bit);
        logic [63:0] src_sum;
        index_pair_t pair;
        if (restart_bit)
            latch_window();
        else
            step_odometer();
        src_sum   = '0;
        pair.last = 1'b1;
        for (int i = 0; i < MAX_AXES; i++) begin
            src_sum = src_sum + axis_base[i] + axis_step[i] * {32'd0, axis_pos[i]};
            if (axis_pos[i] + 32'd1 != axis_count[i])
                pair.last = 1'b0;
        end
        pair.src = OUT_W'(src_sum & IDX_MASK);
        pair.dst = OUT_W'({32'd0, dest_count} & IDX_MASK);
        pair.bad = window_bad;
        return pair;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_AXES; i++) begin
                window_reg[i] = WINDOW_RESET;
                axis_pos[i]   = '0;
                axis_count[i] = 32'd1;
                axis_base[i]  = '0;
                axis_step[i]  = 64'd1;
            end
            dest_count = '0;
            window_bad = 1'b0;
            expected_pairs.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_src_index, m_dst_index, m_last, m_bad_window};
                if (expected_pairs.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result beat with none expected, actual src %h dst %h last %b bad %b",
                             $time, got.src, got.dst, got.last, got.bad);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got !== want) begin
                        mismatch_total++;
                        $display("%0t: mismatch, expected src %h dst %h last %b bad %b",
                                 $time, want.src, want.dst, want.last, want.bad);
                        $display("%0t:           actual src %h dst %h last %b bad %b",
                                 $time, got.src, got.dst, got.last, got.bad);
                    end
                end
            end
            if (cfg_wr_en && cfg_addr < MAX_AXES)
                window_reg[cfg_addr] = cfg_wdata;
            if (s_valid && s_ready) begin
                queued         = next_index_pair(s_restart);
                expected_pairs = {expected_pairs, queued};
            end
        end
        pending <= expected_pairs.size();
    end

endmodule

@@ tb/testbench.sv @@
// top of the testbench: clock, reset, stimulus and verdict for the window address generator
`timescale 1ns / 1ps

module testbench;
    import swag_pkg::*;

    localparam int NUM_AXES    = 7;
    localparam int EXTENT_BITS = 16;
    localparam int INDEX_BITS  = 32;

    // register map: axis i window at index i, top index decodes to nothing
    localparam logic [CFG_IDX_W-1:0] AXIS0_REG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;

    localparam int TOTAL_BEATS      = 1150;
    localparam int CALM_BEATS       = 150;
    localparam int HOLD_PHASE       = 3;
    localparam int PAUSE_PHASE      = 6;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int CYCLE_LIMIT      = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_restart;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_W-1:0]      m_src_index;
    logic [OUT_W-1:0]      m_dst_index;
    logic                  m_last;
    logic                  m_bad_window;

    int mismatch_count;
    int pairs_waiting;
    int beats_sent     = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;   // no idling on either side near the end
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    logic [CFG_DATA_W-1:0] axis_setting [MAX_AXES];

    always #1 aclk = ~aclk;

    strided_window_address_generator_core #(
        .NUM_AXES    (NUM_AXES),
        .EXTENT_BITS (EXTENT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_src_index  (m_src_index),
        .m_dst_index  (m_dst_index),
        .m_last       (m_last),
        .m_bad_window (m_bad_window)
    );

    window_index_checker #(
        .NUM_AXES    (NUM_AXES),
        .EXTENT_BITS (EXTENT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_src_index  (m_src_index),
        .m_dst_index  (m_dst_index),
        .m_last       (m_last),
        .m_bad_window (m_bad_window),
        .errors       (mismatch_count),
        .pending      (pairs_waiting)
    );

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off so the block backs up
    initial begin
        m_ready = 1'b0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                m_ready <= 1'b0;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    function automatic logic [63:0] pack_axis(input logic [15:0] ext, input logic [15:0] first,
                                              input logic [15:0] jump, input logic [15:0] cnt);
        return {cnt, jump, first, ext};
    endfunction

    // mostly small windows so the odometer wraps often, some bad or huge ones
    function automatic logic [63:0] random_axis();
        int unsigned mode, ext, first, jump, cnt, room;
        mode  = $urandom_range(0, 19);
        ext   = $urandom_range(1, 5);
        first = $urandom_range(0, ext - 1);
        jump  = $urandom_range(0, 2);
        room  = (ext - 1 - first) / ((jump == 0) ? 1 : jump) + 1;
        cnt   = 1;
        if (mode < 9) begin
            // single position, the jump never matters
            jump = $urandom_range(0, 16'hffff);
        end else if (mode < 15) begin
            cnt = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, room);
        end else if (mode < 17) begin
            // may run past the extent
            cnt = $urandom_range(1, room + 2);
        end else if (mode < 18) begin
            // auto count with first possibly at or past the extent
            ext   = $urandom_range(0, 3);
            first = $urandom_range(0, 5);
            cnt   = 0;
        end else if (mode < 19) begin
            // large strides, source index wraps
            ext   = $urandom_range(0, 16'hffff);
            first = $urandom_range(0, 16'hffff);
            jump  = $urandom_range(0, 16'hffff);
            cnt   = $urandom_range(1, 3);
        end else begin
            return {$urandom, $urandom};
        end
        return pack_axis(ext[15:0], first[15:0], jump[15:0], cnt[15:0]);
    endfunction

    // offer one beat, hold it until taken, then maybe idle for a burst
    task automatic send_beat(input logic restart_bit);
        s_valid   <= 1'b1;
        s_restart <= restart_bit;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
        if (beats_sent >= TOTAL_BEATS - CALM_BEATS)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // stop offering and wait until every predicted pair has come back
    task automatic settle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pairs_waiting != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // program all axis registers from axis_setting while the block is idle
    task automatic load_axes(input logic touch_unused);
        settle();
        if (touch_unused)
            write_reg(UNUSED_REG, {$urandom, $urandom});
        for (int a = 0; a < MAX_AXES; a++)
            write_reg(CFG_IDX_W'(AXIS0_REG + a), axis_setting[a]);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        int advances;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_restart = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // advances before any restart run on the reset state
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);

        // zero jump and zero count on axis 0, jump 2 on axis 1, 6 elements,
        // walked two past the end so the odometer wraps
        for (int a = 0; a < MAX_AXES; a++)
            axis_setting[a] = pack_axis(16'd1, 16'd0, 16'd1, 16'd1);
        axis_setting[0] = pack_axis(16'd4, 16'd1, 16'd0, 16'd0);
        axis_setting[1] = pack_axis(16'd3, 16'd0, 16'd2, 16'd2);
        load_axes(1'b0);
        send_beat(1'b1);
        repeat (7) send_beat(1'b0);

        // extremes: first past a zero extent, all-max fields, all-zero fields
        for (int a = 1; a < MAX_AXES - 1; a++)
            axis_setting[a] = pack_axis(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        axis_setting[0]            = pack_axis(16'd0, 16'hffff, 16'hffff, 16'd0);
        axis_setting[MAX_AXES - 1] = '0;
        load_axes(1'b0);
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);

        // every register bit set, plus a write to the undecoded index
        for (int a = 0; a < MAX_AXES; a++)
            axis_setting[a] = '1;
        load_axes(1'b1);
        send_beat(1'b1);
        repeat (2) send_beat(1'b0);

        // restart in the middle of a window
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);

        // random windows, each walked for a random number of steps with a
        // rare stray restart mixed in
        phase = 0;
        while (beats_sent < TOTAL_BEATS) begin
            for (int a = 0; a < MAX_AXES; a++)
                axis_setting[a] = random_axis();
            load_axes(phase % 16 == 0);
            send_beat(1'b1);
            advances = (phase == HOLD_PHASE) ? 60 : $urandom_range(1, 40);
            if (phase == HOLD_PHASE)
                long_hold_req = 1'b1;
            for (int n = 0; n < advances; n++) begin
                if (phase == PAUSE_PHASE && n == advances / 2)
                    settle();
                send_beat($urandom_range(0, 31) == 0);
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
